// ===== src/lac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_pkg
// shared types and constants for the line assembler queue
// ----------------------------------------------------------------------------
package lac_pkg;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] DOT_CODE     = 8'd46;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DOT1,
    S_DOT2,
    S_DATA,
    S_TERM
  } lac_state_t;

  typedef struct packed {
    logic       accept;
    logic       emit;
    logic [1:0] status;
    logic       truncated;
    logic       last;
    logic       use_rdata;
    logic       wr_byte;
    logic       wr_dot;
    logic       complete;
    logic       use_saved_chunk;
    logic       drop_step;
    logic       rd_first;
    logic       rd_next;
    logic       pop;
  } lac_cmd_t;

  typedef struct packed {
    logic is_get;
    logic is_newline;
    logic dropping;
    logic at_limit;
    logic full;
    logic empty;
    logic len_zero;
    logic idx_last;
    logic out_free;
  } lac_stat_t;

endpackage

// ===== src/lac_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/lac_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_datapath
// line store, slot ring pointers, line builder and output register
// ----------------------------------------------------------------------------
module lac_datapath import lac_pkg::*; #(
  parameter int LINE_BYTES = 64,
  parameter int LINE_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  lac_cmd_t   cmd,
  output lac_stat_t  stat,
  input  logic       in_tuser,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic [2:0] out_tuser,
  output logic       out_tlast
);

  localparam int OW = $clog2(LINE_BYTES);
  localparam int SW = $clog2(LINE_SLOTS);
  localparam int AW = SW + OW;
  localparam int DEPTH = LINE_SLOTS << OW;

  logic [SW-1:0] write_slot_r, write_slot_nxt;
  logic [SW-1:0] read_slot_r, read_slot_nxt;
  logic [SW-1:0] count_r, count_nxt;
  logic [OW-1:0] build_len_r, build_len_nxt;
  logic          drop_r, drop_nxt;
  logic          chunk_r;
  logic [OW-1:0] idx_r, idx_nxt;
  logic [OW-1:0] slot_len_r [LINE_SLOTS];
  logic [OW-1:0] read_len;
  logic [OW-1:0] done_len;
  logic [OW-1:0] rd_off;
  logic          chunk;

  logic          out_valid_r;
  logic [7:0]    out_data_r;
  logic [2:0]    out_user_r;
  logic          out_last_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    return (s == SW'(LINE_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  assign read_len = slot_len_r[read_slot_r];
  assign done_len = build_len_r + OW'(cmd.wr_dot);
  assign chunk    = cmd.use_saved_chunk ? chunk_r : in_tlast;

  always_comb begin
    stat.is_get     = in_tuser;
    stat.is_newline = (in_tdata == NEWLINE_CODE);
    stat.dropping   = drop_r;
    stat.at_limit   = (build_len_r >= OW'(LINE_BYTES - 4));
    stat.full       = (count_r >= SW'(LINE_SLOTS - 1));
    stat.empty      = (count_r == '0);
    stat.len_zero   = (read_len == '0);
    stat.idx_last   = ({1'b0, idx_r} + 1'b1 >= {1'b0, read_len});
    stat.out_free   = !out_valid_r || out_tready;
  end

  // line store
  assign ram_we    = cmd.wr_byte || cmd.wr_dot;
  assign ram_waddr = {write_slot_r, build_len_r};
  assign ram_wdata = cmd.wr_dot ? DOT_CODE : in_tdata;
  assign ram_re    = cmd.rd_first || cmd.rd_next;
  assign rd_off    = cmd.rd_first ? {OW{1'b0}} : idx_r + 1'b1;
  assign ram_raddr = {read_slot_r, rd_off};

  lac_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    write_slot_nxt = write_slot_r;
    read_slot_nxt  = read_slot_r;
    count_nxt      = count_r;
    build_len_nxt  = build_len_r;
    drop_nxt       = drop_r;
    idx_nxt        = idx_r;
    if (ram_we) begin
      build_len_nxt = build_len_r + 1'b1;
    end
    if (cmd.complete) begin
      build_len_nxt = '0;
      if (stat.full) begin
        if (!chunk) begin
          drop_nxt = 1'b1;
        end
      end else begin
        write_slot_nxt = next_slot(write_slot_r);
        count_nxt      = count_r + 1'b1;
      end
    end
    if (cmd.drop_step && in_tlast) begin
      drop_nxt = 1'b0;
    end
    if (cmd.rd_first) begin
      idx_nxt = '0;
    end else if (cmd.rd_next) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (cmd.pop) begin
      read_slot_nxt = next_slot(read_slot_r);
      count_nxt     = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_slot_r <= '0;
      read_slot_r  <= '0;
      count_r      <= '0;
      build_len_r  <= '0;
      drop_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      write_slot_r <= write_slot_nxt;
      read_slot_r  <= read_slot_nxt;
      count_r      <= count_nxt;
      build_len_r  <= build_len_nxt;
      drop_r       <= drop_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.accept) begin
      chunk_r <= in_tlast;
    end
    if (cmd.complete && !stat.full) begin
      slot_len_r[write_slot_r] <= done_len;
    end
    if (cmd.emit) begin
      out_data_r <= cmd.use_rdata ? ram_rdata : 8'd0;
      out_user_r <= {cmd.truncated, cmd.status};
      out_last_r <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== src/lac_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_ctrl
// controller for put, truncation and get sequences
// ----------------------------------------------------------------------------
module lac_ctrl import lac_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  lac_stat_t stat,
  output lac_cmd_t  cmd
);

  lac_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = stat.out_free;
        if (in_tvalid && stat.out_free) begin
          cmd.accept = 1'b1;
          if (!stat.is_get) begin
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            if (stat.dropping) begin
              cmd.status    = ST_FULL;
              cmd.drop_step = 1'b1;
            end else if (stat.is_newline) begin
              cmd.complete = 1'b1;
              cmd.status   = stat.full ? ST_FULL : ST_OK;
            end else if (stat.at_limit) begin
              cmd.wr_dot    = 1'b1;
              cmd.status    = stat.full ? ST_FULL : ST_OK;
              cmd.truncated = !stat.full;
              state_nxt     = S_DOT1;
            end else begin
              cmd.wr_byte = 1'b1;
              cmd.status  = ST_OK;
            end
          end else if (stat.empty) begin
            cmd.emit   = 1'b1;
            cmd.last   = 1'b1;
            cmd.status = ST_EMPTY;
          end else if (stat.len_zero) begin
            state_nxt = S_TERM;
          end else begin
            cmd.rd_first = 1'b1;
            state_nxt    = S_DATA;
          end
        end
      end
      S_DOT1: begin
        cmd.wr_dot = 1'b1;
        state_nxt  = S_DOT2;
      end
      S_DOT2: begin
        cmd.wr_dot          = 1'b1;
        cmd.complete        = 1'b1;
        cmd.use_saved_chunk = 1'b1;
        state_nxt           = S_IDLE;
      end
      S_DATA: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.use_rdata = 1'b1;
          cmd.status    = ST_OK;
          if (stat.idx_last) begin
            state_nxt = S_TERM;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      S_TERM: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          cmd.status = ST_OK;
          cmd.pop    = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/line_assembler_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_assembler_queue
// newline delimited line fifo: builds lines from put bytes, queues them in a
// ring of slots and plays the oldest line back on get
// ----------------------------------------------------------------------------
//  channel | ports  | tdata   | tuser                    | tlast
//  input   | in_*   | in_byte | command                  | chunk_end
//  result  | out_*  | out_byte| status[1:0], truncated   | last
//
//  put: a put that ends an overlong line writes its "..." bytes one at a time
//  through the single write port of the line store
//  get: one result per cycle after the accept cycle while the output is not
//  stalled, paced by the registered read of the line store
//  reset: synchronous, no clearing pass; line contents need no init
//  a stalled result holds in the output register; input waits while it is full
// ----------------------------------------------------------------------------
module line_assembler_queue import lac_pkg::*; #(
  parameter int LINE_BYTES = 64,
  parameter int LINE_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // in_byte
  input  logic       in_tuser,   // command
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic [2:0] out_tuser,  // status[1:0], truncated
  output logic       out_tlast
);

  lac_cmd_t  cmd;
  lac_stat_t stat;

  lac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lac_datapath #(
    .LINE_BYTES (LINE_BYTES),
    .LINE_SLOTS (LINE_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== src/lac_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_checker
// port level checks for the line assembler queue
// ----------------------------------------------------------------------------
module lac_checker import lac_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser,
  input logic       out_tlast
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // truncation flag only on a successful single put result
  a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tlast && out_tuser[1:0] == ST_OK
      && out_tdata == 8'd0)
    else $error("bad truncated result");

  // error and empty results are single zero transactions
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == ST_FULL || out_tuser[1:0] == ST_EMPTY)
      |-> out_tlast && out_tdata == 8'd0 && !out_tuser[2])
    else $error("bad error result");

  // line bytes only inside an ok get run
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == {1'b0, ST_OK})
    else $error("bad line byte result");

endmodule

bind line_assembler_queue lac_checker u_lac_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
